// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/wtsc_pkg.sv =====
// shared types, codes and constants of the wave-table sound channel
// no dependencies; used by the top level and the checker
package wtsc_pkg;

	localparam int unsigned TICKS_PER_UNIT_DEF = 4;
	localparam int unsigned WAVE_BYTES         = 16;
	localparam int unsigned WAVE_ADDR_W        = 4;
	localparam int unsigned WAVE_POSITIONS     = 32;
	localparam int unsigned POS_W              = 5;
	localparam int unsigned TIMER_W            = 14;
	localparam int unsigned PERIOD_W           = 11;
	localparam int unsigned PERIOD_SPAN        = 1 << PERIOD_W;
	localparam int unsigned FULL_LENGTH        = 256;
	localparam int unsigned LEN_W              = 9;

	typedef enum logic [2:0] {
		MODE_TICK       = 3'd0,
		MODE_LEN_CLK    = 3'd1,
		MODE_REG_WRITE  = 3'd2,
		MODE_REG_READ   = 3'd3,
		MODE_WAVE_WRITE = 3'd4,
		MODE_WAVE_READ  = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		REG_DAC       = 3'd0,
		REG_LENGTH    = 3'd1,
		REG_LEVEL     = 3'd2,
		REG_PERIOD_LO = 3'd3,
		REG_PERIOD_HI = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		LEVEL_MUTE    = 2'd0,
		LEVEL_FULL    = 2'd1,
		LEVEL_HALF    = 2'd2,
		LEVEL_QUARTER = 2'd3
	} level_code_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [2:0] reg_index;
		logic [3:0] wave_index;
		logic [7:0] write_data;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0]         read_data;
		logic [3:0]         sample_level;
		logic signed [15:0] sample_value;
		logic               channel_on;
	} res_item_t;

	// (2*level - 15) * 2000
	function automatic logic signed [15:0] level_to_value(input logic [3:0] level);
		logic signed [5:0] centered;
		centered = $signed({1'b0, level, 1'b0}) - 6'sd15;
		return 16'(centered * 16'sd2000);
	endfunction

endpackage

// ===== rtl/wave_table_sound_channel.sv =====
// wave-table sound channel: timer, wave store, length counter and result register
// depends on wtsc_pkg
//
// usage:
// - cmd channel (cmd_valid / cmd_stall / cmd) takes one event per item: a period
//   tick, a length clock, a register write or read, or a wave store write or read
// - res channel (res_valid / res_stall / res) returns exactly one item per command,
//   in order: read byte, scaled sample level, signed sample and the on flag, all
//   showing the state after the event
// - the result is registered and is offered in the cycle after its command is
//   accepted
// - throughput is one item per cycle while no stalled result is held; all state
//   updates and the sample scaling sit between command port and result register
// - a stalled result holds; cmd_stall is raised only while a result is held and
//   stalled, so a new command is taken whenever the held result leaves that cycle
// - reset clears all channel state, including the 16-byte wave store, to zero and
//   empties the result register; commands are accepted in the first cycle after it
module wave_table_sound_channel #(
	parameter int unsigned TICKS_PER_PERIOD_UNIT = wtsc_pkg::TICKS_PER_UNIT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  wtsc_pkg::cmd_item_t cmd,
	output logic                res_valid,
	input  logic                res_stall,
	output wtsc_pkg::res_item_t res
);
	import wtsc_pkg::*;

	logic [7:0]          wave_q [WAVE_BYTES];
	logic [TIMER_W-1:0]  timer_q,    timer_d;
	logic [POS_W-1:0]    pos_q,      pos_d;
	logic [LEN_W-1:0]    len_q,      len_d;
	logic [PERIOD_W-1:0] period_q,   period_d;
	logic                len_en_q,   len_en_d;
	logic [1:0]          lvl_code_q, lvl_code_d;
	logic                dac_q,      dac_d;
	logic                active_q,   active_d;
	logic [3:0]          nibble_q,   nibble_d;

	logic                res_valid_q;
	res_item_t           res_q, res_d;

	logic                   accept;
	logic [WAVE_ADDR_W-1:0] rd_addr;
	logic [7:0]             rd_byte;
	logic [7:0]             read_data;
	logic [3:0]             level;

	function automatic logic [TIMER_W-1:0] reload_amount(input logic [PERIOD_W-1:0] pv);
		logic [PERIOD_W:0] span;
		span = (PERIOD_W+1)'(PERIOD_SPAN) - {1'b0, pv};
		return TIMER_W'(TIMER_W'(span) * TIMER_W'(TICKS_PER_PERIOD_UNIT));
	endfunction

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = res_valid_q && res_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// one read port: a tick fetches the playing byte, a wave read the addressed one
	assign rd_addr = (cmd.mode == MODE_TICK) ? pos_q[POS_W-1:1] : cmd.wave_index;
	assign rd_byte = wave_q[rd_addr];

	always_comb begin
		timer_d    = timer_q;
		pos_d      = pos_q;
		len_d      = len_q;
		period_d   = period_q;
		len_en_d   = len_en_q;
		lvl_code_d = lvl_code_q;
		dac_d      = dac_q;
		active_d   = active_q;
		nibble_d   = nibble_q;
		read_data  = 8'h00;

		case (cmd.mode)
			MODE_TICK: begin
				if (active_q) begin
					if (timer_q <= TIMER_W'(1)) begin
						nibble_d = pos_q[0] ? rd_byte[3:0] : rd_byte[7:4];
						// reload keeps the overshoot of an expired timer
						timer_d  = TIMER_W'(reload_amount(period_q) + timer_q - TIMER_W'(1));
						pos_d    = pos_q + POS_W'(1);
					end else begin
						timer_d = timer_q - TIMER_W'(1);
					end
				end
			end
			MODE_LEN_CLK: begin
				if (len_en_q && (len_q != '0)) begin
					len_d = len_q - LEN_W'(1);
					if (len_q == LEN_W'(1))
						active_d = 1'b0;
				end
			end
			MODE_REG_WRITE: begin
				case (cmd.reg_index)
					REG_DAC: begin
						dac_d = cmd.write_data[7];
						if (!cmd.write_data[7])
							active_d = 1'b0;
					end
					REG_LENGTH: begin
						len_d = LEN_W'(FULL_LENGTH) - {1'b0, cmd.write_data};
					end
					REG_LEVEL: begin
						lvl_code_d = cmd.write_data[6:5];
					end
					REG_PERIOD_LO: begin
						period_d = {period_q[PERIOD_W-1:8], cmd.write_data};
					end
					REG_PERIOD_HI: begin
						len_en_d = cmd.write_data[6];
						period_d = {cmd.write_data[2:0], period_q[7:0]};
						// trigger uses the period just written
						if (cmd.write_data[7]) begin
							active_d = dac_q;
							if (len_q == '0)
								len_d = LEN_W'(FULL_LENGTH);
							timer_d = reload_amount({cmd.write_data[2:0], period_q[7:0]});
							pos_d   = '0;
						end
					end
					default: begin
					end
				endcase
			end
			MODE_REG_READ: begin
				case (cmd.reg_index)
					REG_DAC:       read_data = {dac_q, 7'h7F};
					REG_LEVEL:     read_data = {1'b1, lvl_code_q, 5'h1F};
					REG_PERIOD_HI: read_data = {1'b1, len_en_q, 6'h3F};
					default:       read_data = 8'hFF;
				endcase
			end
			MODE_WAVE_READ: begin
				read_data = rd_byte;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		case (lvl_code_d)
			LEVEL_FULL:    level = nibble_d;
			LEVEL_HALF:    level = {1'b0, nibble_d[3:1]};
			LEVEL_QUARTER: level = {2'b00, nibble_d[3:2]};
			default:       level = 4'h0;
		endcase

		res_d.read_data    = read_data;
		res_d.channel_on   = active_d;
		res_d.sample_level = active_d ? level : 4'h0;
		res_d.sample_value = active_d ? level_to_value(level) : 16'sd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q    <= '0;
			pos_q      <= '0;
			len_q      <= '0;
			period_q   <= '0;
			len_en_q   <= 1'b0;
			lvl_code_q <= '0;
			dac_q      <= 1'b0;
			active_q   <= 1'b0;
			nibble_q   <= '0;
		end else if (accept) begin
			timer_q    <= timer_d;
			pos_q      <= pos_d;
			len_q      <= len_d;
			period_q   <= period_d;
			len_en_q   <= len_en_d;
			lvl_code_q <= lvl_code_d;
			dac_q      <= dac_d;
			active_q   <= active_d;
			nibble_q   <= nibble_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WAVE_BYTES; i++)
				wave_q[i] <= 8'h00;
		end else if (accept && (cmd.mode == MODE_WAVE_WRITE)) begin
			wave_q[cmd.wave_index] <= cmd.write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			res_q <= res_d;
	end

endmodule

// ===== rtl/wtsc_checker.sv =====
// port-level checks of the wave-table sound channel, bound to the top level
// depends on wtsc_pkg and assert_macros.svh
`include "assert_macros.svh"

module wtsc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                cmd_valid,
	input logic                cmd_stall,
	input logic                res_valid,
	input logic                res_stall,
	input wtsc_pkg::res_item_t res
);

	// a held result stays offered and unchanged
	`ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res), "stalled result item changed")

	// every accepted item produces a result in the next cycle
	`ASSERT_NEXT(a_cmd_to_res, clk, arst_n, cmd_valid && !cmd_stall, res_valid, "accepted item gave no result")

	// commands are held off only by a stalled result
	`ASSERT_IMPLY(a_stall_cause, clk, arst_n, cmd_stall, res_valid && res_stall, "command stalled without a held result")

	// a taken result with no new item leaves the output empty
	`ASSERT_NEXT(a_res_drain, clk, arst_n, res_valid && !res_stall && !(cmd_valid && !cmd_stall), !res_valid, "result item repeated")

	// a channel that is off outputs zero samples
	`ASSERT_IMPLY(a_off_silent, clk, arst_n, res_valid && !res.channel_on, (res.sample_level == 4'h0) && (res.sample_value == 16'sd0), "channel off but sample nonzero")

endmodule

bind wave_table_sound_channel wtsc_checker u_wtsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

// ===== bench/tb.sv =====
// self-checking bench for wave_table_sound_channel: directed events, then random sequences
// depends on wtsc_pkg and the wave_table_sound_channel rtl; a clocked driver and monitor
// push events and compare each result with a cycle-free model of the channel
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wtsc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_TARGET = 540;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_item_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_item_t res;

	wave_table_sound_channel dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// channel state as the model sees it
	logic [7:0]  wave_copy [WAVE_BYTES];
	logic [13:0] period_timer_m = '0;
	logic [4:0]  wave_pos_m = '0;
	logic [8:0]  length_m = '0;
	logic [10:0] period_m = '0;
	logic        length_en_m = 1'b0;
	logic [1:0]  level_m = LEVEL_MUTE;
	logic        dac_m = 1'b0;
	logic        on_m = 1'b0;
	logic [3:0]  nibble_m = '0;

	cmd_item_t event_queue[$];
	res_item_t channel_outputs[$];
	int unsigned counted_events = 0;
	int unsigned item_total = 0;
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned errors = 0;
	int unsigned cycle_count = 0;

	function automatic logic [13:0] reload_ticks();
		return 14'((PERIOD_SPAN - period_m) * TICKS_PER_UNIT_DEF);
	endfunction

	function automatic res_item_t step_channel(input cmd_item_t c);
		res_item_t r;
		logic [7:0] wbyte;
		logic [3:0] lvl;
		int centered_val;
		r = '0;
		case (c.mode)
			MODE_TICK: begin
				if (on_m) begin
					if (period_timer_m <= 14'd1) begin
						wbyte = wave_copy[wave_pos_m[4:1]];
						nibble_m = wave_pos_m[0] ? wbyte[3:0] : wbyte[7:4];
						// reload keeps the leftover of the expiring count
						period_timer_m = reload_ticks() + period_timer_m - 14'd1;
						wave_pos_m = wave_pos_m + 5'd1;
					end else begin
						period_timer_m = period_timer_m - 14'd1;
					end
				end
			end
			MODE_LEN_CLK: begin
				if (length_en_m && length_m != 9'd0) begin
					length_m = length_m - 9'd1;
					if (length_m == 9'd0)
						on_m = 1'b0;
				end
			end
			MODE_REG_WRITE: begin
				case (c.reg_index)
					REG_DAC: begin
						dac_m = c.write_data[7];
						if (!dac_m)
							on_m = 1'b0;
					end
					REG_LENGTH: length_m = 9'(FULL_LENGTH - c.write_data);
					REG_LEVEL: level_m = c.write_data[6:5];
					REG_PERIOD_LO: period_m[7:0] = c.write_data;
					REG_PERIOD_HI: begin
						length_en_m = c.write_data[6];
						period_m[10:8] = c.write_data[2:0];
						if (c.write_data[7]) begin
							on_m = dac_m;
							if (length_m == 9'd0)
								length_m = 9'(FULL_LENGTH);
							period_timer_m = reload_ticks();
							wave_pos_m = '0;
						end
					end
					default: ;
				endcase
			end
			MODE_REG_READ: begin
				// unused bits read as ones
				case (c.reg_index)
					REG_DAC: r.read_data = {dac_m, 7'h7F};
					REG_LEVEL: r.read_data = {1'b1, level_m, 5'h1F};
					REG_PERIOD_HI: r.read_data = {1'b1, length_en_m, 6'h3F};
					default: r.read_data = 8'hFF;
				endcase
			end
			MODE_WAVE_WRITE: wave_copy[c.wave_index] = c.write_data;
			MODE_WAVE_READ: r.read_data = wave_copy[c.wave_index];
			default: ;
		endcase
		if (on_m) begin
			lvl = (level_m == LEVEL_MUTE) ? 4'd0 : nibble_m >> (level_m - 2'd1);
			centered_val = (2 * int'(lvl) - 15) * 2000;
			r.sample_level = lvl;
			r.sample_value = 16'(centered_val);
		end
		r.channel_on = on_m;
		return r;
	endfunction

	task automatic add_cmd(input logic [2:0] m, input logic [2:0] ridx, input logic [3:0] widx,
			input logic [7:0] d);
		cmd_item_t c;
		c.mode = m;
		c.reg_index = ridx;
		c.wave_index = widx;
		c.write_data = d;
		event_queue.push_back(c);
		if (m <= MODE_WAVE_READ)
			counted_events++;
	endtask

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		errors++;
		$display("result %0d: %s is %h, expected %h", results_seen, what, got, want);
	endtask

	function automatic int sender_idle_pct();
		if (items_sent < item_total / 3)
			return 30;
		else if (items_sent < 2 * item_total / 3)
			return 87;
		return 0;
	endfunction

	function automatic int receiver_idle_pct();
		if (results_seen < item_total / 3)
			return 87;
		else if (results_seen < 2 * item_total / 3)
			return 30;
		return 0;
	endfunction

	// driver: the model advances on the edge that takes the item
	always @(posedge clk or negedge arst_n) begin
		logic hold;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
		end else begin
			hold = cmd_valid && cmd_stall;
			if (cmd_valid && !cmd_stall) begin
				channel_outputs.push_back(step_channel(cmd));
				items_sent++;
			end
			if (!hold) begin
				if (event_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
					cmd <= event_queue.pop_front();
					cmd_valid <= 1'b1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		res_item_t want;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (channel_outputs.size() == 0) begin
					report_mismatch("item with nothing outstanding", 16'(res), 16'h0);
				end else begin
					want = channel_outputs.pop_front();
					if (res.read_data !== want.read_data)
						report_mismatch("read_data", 16'(res.read_data),
							16'(want.read_data));
					if (res.sample_level !== want.sample_level)
						report_mismatch("sample_level", 16'(res.sample_level),
							16'(want.sample_level));
					if (res.sample_value !== want.sample_value)
						report_mismatch("sample_value", res.sample_value, want.sample_value);
					if (res.channel_on !== want.channel_on)
						report_mismatch("channel_on", 16'(res.channel_on),
							16'(want.channel_on));
				end
				results_seen++;
			end
			res_stall <= ($urandom_range(0, 99) < receiver_idle_pct());
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("wave_table_sound_channel test failed");
			$finish;
		end
	end

	initial begin
		int pick;
		int sub;
		foreach (wave_copy[i])
			wave_copy[i] = 8'h00;

		// directed: wave store edges, a full-rate start, reads, length expiry, dead triggers
		add_cmd(MODE_WAVE_WRITE, REG_DAC, 4'd0, 8'hF0);
		add_cmd(MODE_WAVE_WRITE, REG_DAC, 4'd15, 8'h5A);
		add_cmd(MODE_WAVE_READ, REG_DAC, 4'd15, 8'h00);
		add_cmd(MODE_REG_WRITE, REG_DAC, 4'd0, 8'h80);
		add_cmd(MODE_REG_WRITE, REG_LEVEL, 4'd0, 8'h20);
		add_cmd(MODE_REG_WRITE, REG_PERIOD_LO, 4'd0, 8'hFF);
		add_cmd(MODE_REG_WRITE, REG_LENGTH, 4'd0, 8'hFF);
		add_cmd(MODE_REG_WRITE, REG_PERIOD_HI, 4'd0, 8'hC7);
		repeat (5)
			add_cmd(MODE_TICK, 3'd0, 4'd0, 8'h00);
		add_cmd(MODE_REG_READ, REG_DAC, 4'd0, 8'h00);
		add_cmd(MODE_REG_READ, REG_LEVEL, 4'd0, 8'h00);
		add_cmd(MODE_REG_READ, REG_PERIOD_HI, 4'd0, 8'h00);
		add_cmd(MODE_REG_READ, 3'd6, 4'd0, 8'h00);
		add_cmd(MODE_REG_WRITE, 3'd5, 4'd0, 8'hFF);
		add_cmd(3'd6, 3'd7, 4'd15, 8'hFF);
		add_cmd(3'd7, 3'd0, 4'd0, 8'h00);
		// length of one runs out on the first length clock
		add_cmd(MODE_LEN_CLK, 3'd0, 4'd0, 8'h00);
		add_cmd(MODE_TICK, 3'd0, 4'd0, 8'h00);
		add_cmd(MODE_REG_WRITE, REG_LEVEL, 4'd0, 8'h60);
		add_cmd(MODE_REG_WRITE, REG_DAC, 4'd0, 8'h00);
		// trigger with the dac off leaves the channel off and refills the length
		add_cmd(MODE_REG_WRITE, REG_PERIOD_HI, 4'd0, 8'h80);
		add_cmd(MODE_REG_WRITE, REG_DAC, 4'd0, 8'hFF);
		add_cmd(MODE_REG_WRITE, REG_PERIOD_HI, 4'd0, 8'h80);

		while (counted_events < RANDOM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				add_cmd(3'($urandom), 3'($urandom), 4'($urandom), 8'($urandom));
			end else if (pick < 35) begin
				// start-up sequence with random content, mostly short periods and lengths
				repeat ($urandom_range(0, 4))
					add_cmd(MODE_WAVE_WRITE, 3'($urandom), 4'($urandom), 8'($urandom));
				add_cmd(MODE_REG_WRITE, REG_DAC, 4'($urandom),
					{($urandom_range(0, 9) != 0), 7'($urandom)});
				add_cmd(MODE_REG_WRITE, REG_LEVEL, 4'($urandom), 8'($urandom));
				add_cmd(MODE_REG_WRITE, REG_PERIOD_LO, 4'($urandom),
					($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(240, 255)));
				add_cmd(MODE_REG_WRITE, REG_LENGTH, 4'($urandom),
					($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(235, 255)));
				add_cmd(MODE_REG_WRITE, REG_PERIOD_HI, 4'($urandom),
					{($urandom_range(0, 7) != 0), 1'($urandom), 3'($urandom),
					($urandom_range(0, 5) == 0) ? 3'($urandom) : 3'd7});
			end else begin
				repeat ($urandom_range(4, 30)) begin
					sub = $urandom_range(0, 99);
					if (sub < 70)
						add_cmd(MODE_TICK, 3'($urandom), 4'($urandom), 8'($urandom));
					else if (sub < 80)
						add_cmd(MODE_LEN_CLK, 3'($urandom), 4'($urandom), 8'($urandom));
					else if (sub < 88)
						add_cmd(MODE_WAVE_READ, 3'($urandom), 4'($urandom), 8'($urandom));
					else if (sub < 94)
						add_cmd(MODE_REG_READ, 3'($urandom), 4'($urandom), 8'($urandom));
					else
						add_cmd(MODE_WAVE_WRITE, 3'($urandom), 4'($urandom), 8'($urandom));
				end
			end
		end
		item_total = event_queue.size();

		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every queued item must come back before the verdict
		while (results_seen < item_total)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
		if (errors == 0)
			$display("wave_table_sound_channel test passed");
		else
			$display("wave_table_sound_channel test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/wtsc_pkg.sv
rtl/wave_table_sound_channel.sv
rtl/wtsc_checker.sv
bench/tb.sv
